/* hdl/quadrature_encoder_step_counter_top_defines.svh */
// Assertion macros shared by the quadrature encoder step counter RTL.
`ifndef QUADRATURE_ENCODER_STEP_COUNTER_TOP_DEFINES_SVH
`define QUADRATURE_ENCODER_STEP_COUNTER_TOP_DEFINES_SVH

// Same-cycle implication, clocked on clk_i and disabled during reset.
`define QESC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i and disabled during reset.
`define QESC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/qesc_pkg.sv */
// Types, constants and the quadrature decode table of the encoder step counter.
package qesc_pkg;

  localparam int unsigned NumEncodersDef = 16;
  localparam int unsigned IdxW           = 4;
  localparam int unsigned SampleW        = 2;
  localparam int unsigned PpsW           = 7;
  localparam int unsigned SumW           = 8;
  localparam int unsigned CountW         = 16;
  localparam int unsigned PulseW         = 2;

  localparam logic [PpsW-1:0] PpsReset = 7'd4;

  localparam logic signed [PulseW-1:0] PulseNone = 2'sb00;
  localparam logic signed [PulseW-1:0] PulseUp   = 2'sb01;
  localparam logic signed [PulseW-1:0] PulseDown = 2'sb11;

  localparam logic signed [SumW-1:0] SumMax = 8'sh7F;
  localparam logic signed [SumW-1:0] SumMin = 8'sh80;

  localparam logic [CountW-1:0] CountInc = 16'h0001;
  localparam logic [CountW-1:0] CountDec = 16'hFFFF;

  typedef struct packed {
    logic        [CountW-1:0]  count;
    logic signed [SumW-1:0]    sum;
    logic                      dir;
    logic        [SampleW-1:0] prev;
  } entry_t;

  typedef struct packed {
    logic signed [CountW-1:0] step_total;
    logic signed [PulseW-1:0] step_event;
    logic signed [PulseW-1:0] quarter_pulse;
  } result_t;

  function automatic logic signed [PulseW-1:0] quad_decode(input logic [3:0] code);
    logic signed [PulseW-1:0] p;
    unique case (code)
      4'd1, 4'd7, 4'd8, 4'd14: p = PulseDown;
      4'd2, 4'd4, 4'd11, 4'd13: p = PulseUp;
      default: p = PulseNone;
    endcase
    return p;
  endfunction

endpackage

/* hdl/qesc_state_mem.sv */
// Per-encoder state memory with valid bits, registered read and write forwarding.
module qesc_state_mem
  import qesc_pkg::*;
#(
  parameter int unsigned NumEntries = NumEncodersDef,
  parameter int unsigned AddrW      = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  entry_t           wr_data_i,
  output entry_t           rd_data_o
);

  entry_t                  mem [NumEntries];
  logic [NumEntries-1:0]   valid_q;
  entry_t                  rd_q;
  entry_t                  fwd_q;
  logic                    hit_q;
  logic                    rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q  <= mem[rd_addr_i];
      fwd_q <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      hit_q      <= 1'b0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        hit_q      <= wr_en_i && (wr_addr_i == rd_addr_i);
        rd_valid_q <= valid_q[rd_addr_i];
      end
    end
  end

  always_comb begin
    if (hit_q) begin
      rd_data_o = fwd_q;
    end else if (rd_valid_q) begin
      rd_data_o = rd_q;
    end else begin
      rd_data_o = '0;
    end
  end

endmodule

/* hdl/qesc_update.sv */
// Decode of one sample and the update of its encoder's state entry.
module qesc_update
  import qesc_pkg::*;
(
  input  entry_t            entry_i,
  input  logic [SampleW-1:0] sample_i,
  input  logic [PpsW-1:0]   pps_i,
  input  logic              in_range_i,
  output entry_t            entry_o,
  output result_t           result_o
);

  logic signed [PulseW-1:0] pulse;
  logic signed [SumW:0]     sum_ext;
  logic signed [SumW-1:0]   sum_sat;
  logic        [SumW-1:0]   mag;
  logic                     new_dir;
  logic signed [PulseW-1:0] event_v;

  always_comb begin
    pulse   = quad_decode({entry_i.prev, sample_i});
    sum_ext = {entry_i.sum[SumW-1], entry_i.sum}
            + {{(SumW + 1 - PulseW){pulse[PulseW-1]}}, pulse};
    if (sum_ext[SumW] != sum_ext[SumW-1]) begin
      sum_sat = sum_ext[SumW] ? SumMin : SumMax;
    end else begin
      sum_sat = sum_ext[SumW-1:0];
    end
    mag     = sum_sat[SumW-1] ? (~sum_sat + 1'b1) : sum_sat;
    new_dir = !pulse[PulseW-1];
    event_v = PulseNone;

    entry_o      = entry_i;
    entry_o.prev = sample_i;
    if (pulse != PulseNone) begin
      entry_o.sum = sum_sat;
      entry_o.dir = new_dir;
      if ((entry_i.dir == new_dir) && (mag >= {1'b0, pps_i})) begin
        event_v       = new_dir ? PulseUp : PulseDown;
        entry_o.count = entry_i.count + (new_dir ? CountInc : CountDec);
        entry_o.sum   = '0;
      end
    end

    if (in_range_i) begin
      result_o.step_total    = entry_o.count;
      result_o.step_event    = event_v;
      result_o.quarter_pulse = pulse;
    end else begin
      result_o = '0;
    end
  end

endmodule

/* hdl/quadrature_encoder_step_counter_top.sv */
// Top level of the scanned quadrature encoder step counter.
//
//   Channel   Direction  Payload (low bit up)
//   s_axis    in         encoder_index[3:0], ab_sample[5:4]
//   m_axis    out        step_total[15:0], step_event[17:16], quarter_pulse[19:18]
//   cfg       in         pulses_per_step[6:0]
//
// One beat per cycle is accepted while the output side takes results.
// Each beat takes a state memory read, then update, write-back and a registered result.
// A write to the entry being read in the same cycle is forwarded to the next update.
// Reset clears the per-entry valid bits at once; there is no clearing pass.
// A stalled output holds one result; one further beat waits in the update stage.
`include "quadrature_encoder_step_counter_top_defines.svh"

module quadrature_encoder_step_counter_top
  import qesc_pkg::*;
#(
  parameter int unsigned NUM_ENCODERS = NumEncodersDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  input  logic [7:0]      s_axis_tdata,   // encoder_index, ab_sample
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  output logic [23:0]     m_axis_tdata,   // step_total, step_event, quarter_pulse
  input  logic            cfg_we_i,
  input  logic [PpsW-1:0] cfg_wdata_i
);

  localparam int unsigned AddrW = (NUM_ENCODERS > 1) ? $clog2(NUM_ENCODERS) : 1;
  localparam int unsigned CmpW  = 10;
  localparam logic [CmpW-1:0] NumEnc = CmpW'(NUM_ENCODERS);

  logic [PpsW-1:0]       pps_q;
  logic [IdxW-1:0]       in_idx;
  logic [SampleW-1:0]    in_sample;
  logic [IdxW+AddrW-1:0] idx_wide;
  logic [AddrW-1:0]      in_addr;
  logic                  in_range;
  logic                  s_accept;
  logic                  advance;
  logic                  out_load;
  logic                  wr_en;

  logic                  s1_valid_q;
  logic [AddrW-1:0]      s1_addr_q;
  logic [SampleW-1:0]    s1_sample_q;
  logic                  s1_in_range_q;

  logic                  out_valid_q;
  result_t               out_q;

  entry_t                rd_entry;
  entry_t                upd_entry;
  result_t               upd_res;

  assign in_idx    = s_axis_tdata[IdxW-1:0];
  assign in_sample = s_axis_tdata[IdxW+SampleW-1:IdxW];
  assign idx_wide  = {{AddrW{1'b0}}, in_idx};
  assign in_addr   = idx_wide[AddrW-1:0];
  assign in_range  = {{(CmpW - IdxW){1'b0}}, in_idx} < NumEnc;

  assign advance       = s1_valid_q && (!out_valid_q || m_axis_tready);
  assign out_load      = advance;
  assign s_axis_tready = !s1_valid_q || advance;
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign wr_en         = advance && s1_in_range_q;

  qesc_state_mem #(
    .NumEntries (NUM_ENCODERS),
    .AddrW      (AddrW)
  ) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (s_accept && in_range),
    .rd_addr_i (in_addr),
    .wr_en_i   (wr_en),
    .wr_addr_i (s1_addr_q),
    .wr_data_i (upd_entry),
    .rd_data_o (rd_entry)
  );

  qesc_update u_update (
    .entry_i    (rd_entry),
    .sample_i   (s1_sample_q),
    .pps_i      (pps_q),
    .in_range_i (s1_in_range_q),
    .entry_o    (upd_entry),
    .result_o   (upd_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pps_q       <= PpsReset;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        pps_q <= cfg_wdata_i;
      end
      if (s_accept) begin
        s1_valid_q <= 1'b1;
      end else if (advance) begin
        s1_valid_q <= 1'b0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      s1_addr_q     <= in_addr;
      s1_sample_q   <= in_sample;
      s1_in_range_q <= in_range;
    end
    if (out_load) begin
      out_q <= upd_res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, out_q.quarter_pulse, out_q.step_event, out_q.step_total};

  `QESC_ASSERT_NEXT(a_s1_hold, s1_valid_q && !advance,
                    s1_valid_q && $stable(s1_addr_q) && $stable(s1_sample_q),
                    "Update stage lost its beat while stalled.")
  `QESC_ASSERT_NEXT(a_accept_fills, s_accept, s1_valid_q,
                    "Accepted beat did not reach the update stage.")
  `QESC_ASSERT_IMPL(a_event_dir, out_load && (upd_res.step_event != PulseNone),
                    upd_res.step_event == upd_res.quarter_pulse,
                    "Step counted against the decoded direction.")
  `QESC_ASSERT_IMPL(a_range_zero, out_load && !s1_in_range_q, upd_res == '0,
                    "Result for an absent encoder is not zero.")

endmodule

/* bench/quadrature_encoder_step_counter_top_tb.sv */
// Self-checking testbench for the scanned quadrature encoder step counter.
module quadrature_encoder_step_counter_top_tb;
  import qesc_pkg::*;

  localparam int NumEnc     = 16;
  localparam int NumPhases  = 7;
  localparam int PhaseBeats = 250;
  localparam int IdleLimit  = 4000;

  class step_count_tracker;
    logic        [SampleW-1:0] last_ab [NumEnc];
    logic                      dir_up  [NumEnc];
    logic signed [SumW-1:0]    qsum    [NumEnc];
    logic        [CountW-1:0]  steps   [NumEnc];
    logic        [PpsW-1:0]    pps;
    result_t                   expected_results [$];
    int                        errors;

    function new();
      pps    = PpsReset;
      errors = 0;
      for (int i = 0; i < NumEnc; i++) begin
        last_ab[i] = '0;
        dir_up[i]  = 1'b0;
        qsum[i]    = '0;
        steps[i]   = '0;
      end
    endfunction

    // Position of a sample along the forward Gray sequence 00, 10, 11, 01.
    static function logic [1:0] ring_pos(logic [1:0] s);
      return {s[0], s[1] ^ s[0]};
    endfunction

    function void set_pulses_per_step(logic [PpsW-1:0] v);
      pps = v;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function void note_input(logic [7:0] beat);
      logic        [IdxW-1:0]    enc;
      logic        [SampleW-1:0] ab;
      logic        [1:0]         delta;
      logic signed [PulseW-1:0]  pulse;
      logic signed [PulseW-1:0]  step_dir;
      int                        sum_i;
      int                        mag;
      result_t                   r;
      enc      = beat[3:0];
      ab       = beat[5:4];
      delta    = ring_pos(ab) - ring_pos(last_ab[enc]);
      pulse    = (delta == 2'd1) ? PulseUp : (delta == 2'd3) ? PulseDown : PulseNone;
      step_dir = PulseNone;
      last_ab[enc] = ab;
      if (pulse != PulseNone) begin
        sum_i = int'(qsum[enc]) + int'(pulse);
        if (sum_i > int'(SumMax)) sum_i = int'(SumMax);
        if (sum_i < int'(SumMin)) sum_i = int'(SumMin);
        qsum[enc] = sum_i[SumW-1:0];
        mag = (sum_i < 0) ? -sum_i : sum_i;
        if ((dir_up[enc] == (pulse == PulseUp)) && (mag >= int'(pps))) begin
          step_dir   = pulse;
          steps[enc] = steps[enc] + ((pulse == PulseUp) ? CountInc : CountDec);
          qsum[enc]  = '0;
        end
        dir_up[enc] = (pulse == PulseUp);
      end
      r.step_total    = steps[enc];
      r.step_event    = step_dir;
      r.quarter_pulse = pulse;
      expected_results.push_back(r);
    endfunction

    task report_mismatch(string what);
      if (errors < 100) $display("mismatch: %s", what);
      errors++;
    endtask

    task check(logic [23:0] beat);
      result_t e;
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result beat %h", beat));
        return;
      end
      e = expected_results.pop_front();
      if (beat[15:0] !== e.step_total)
        report_mismatch($sformatf("step_total %h, expected %h", beat[15:0], e.step_total));
      if (beat[17:16] !== e.step_event)
        report_mismatch($sformatf("step_event %h, expected %h", beat[17:16], e.step_event));
      if (beat[19:18] !== e.quarter_pulse)
        report_mismatch($sformatf("quarter_pulse %h, expected %h", beat[19:18],
                                  e.quarter_pulse));
    endtask
  endclass

  logic            clk_i         = 1'b0;
  logic            rst_ni        = 1'b0;
  logic            s_axis_tvalid = 1'b0;
  logic            s_axis_tready;
  logic [7:0]      s_axis_tdata  = '0;
  logic            m_axis_tvalid;
  logic            m_axis_tready = 1'b0;
  logic [23:0]     m_axis_tdata;
  logic            cfg_we_i      = 1'b0;
  logic [PpsW-1:0] cfg_wdata_i   = '0;

  step_count_tracker     tracker = new();
  logic [SampleW-1:0]    ab_sent [NumEnc];
  int                    gap_pct   = 0;
  int                    stall_pct = 0;
  int                    idle_cycles = 0;

  quadrature_encoder_step_counter_top u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) tracker.check(m_axis_tdata);
      if (s_axis_tvalid && s_axis_tready) tracker.note_input(s_axis_tdata);
      if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IdleLimit) begin
          $display("status: fail");
          $finish;
        end
      end
    end
  end

  task send_sample(input logic [IdxW-1:0] enc, input logic [SampleW-1:0] ab);
    while ((gap_pct != 0) && ($urandom_range(99) < gap_pct)) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, ab, enc};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    ab_sent[enc] = ab;
  endtask

  task drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task write_pulses_per_step(input logic [PpsW-1:0] v);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    tracker.set_pulses_per_step(v);
  endtask

  function automatic logic [SampleW-1:0] sample_at(logic [1:0] p);
    return {p[1] ^ p[0], p[1]};
  endfunction

  task random_phase(input int pps_now);
    int              n;
    int              len;
    int              r;
    logic            up;
    logic [IdxW-1:0] enc;
    logic [1:0]      p;
    n = 0;
    while (n < PhaseBeats) begin
      enc = IdxW'($urandom_range(NumEnc - 1));
      if ($urandom_range(99) < 80) begin
        up  = 1'($urandom_range(1));
        len = $urandom_range(1, 2 * pps_now + 4);
        for (int k = 0; k < len && n < PhaseBeats; k++) begin
          if ($urandom_range(99) < 3) up = ~up;
          p = step_count_tracker::ring_pos(ab_sent[enc]);
          r = $urandom_range(99);
          if (r < 6) begin
          end else if (r < 9) begin
            p = p + 2'd2;
          end else begin
            p = up ? p + 2'd1 : p - 2'd1;
          end
          send_sample(enc, sample_at(p));
          n++;
        end
      end else begin
        send_sample(enc, SampleW'($urandom_range(3)));
        n++;
      end
    end
  endtask

  initial begin
    int pps_list [NumPhases];
    for (int i = 0; i < NumEnc; i++) ab_sent[i] = '0;
    pps_list = '{4, 1, 0, 127, 2, 1, 3};
    pps_list[5] = $urandom_range(1, 127);

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // One forward detent on encoder 0, a still sample and an illegal jump.
    send_sample(4'd0, 2'd2);
    send_sample(4'd0, 2'd3);
    send_sample(4'd0, 2'd1);
    send_sample(4'd0, 2'd0);
    send_sample(4'd0, 2'd0);
    send_sample(4'd0, 2'd3);
    // One backward detent on encoder 15 wraps its count below zero.
    send_sample(4'd15, 2'd1);
    send_sample(4'd15, 2'd3);
    send_sample(4'd15, 2'd2);
    send_sample(4'd15, 2'd0);
    send_sample(4'd5, 2'd0);

    // With a zero threshold every pulse in a repeated direction is a step.
    write_pulses_per_step('0);
    send_sample(4'd7, 2'd1);
    send_sample(4'd7, 2'd0);
    send_sample(4'd7, 2'd2);
    send_sample(4'd10, 2'd2);

    for (int ph = 0; ph < NumPhases; ph++) begin
      write_pulses_per_step(PpsW'(pps_list[ph]));
      case (ph % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 53; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 53; end
        default: begin gap_pct = 16; stall_pct = 16; end
      endcase
      random_phase(pps_list[ph]);
    end

    drain();
    repeat (8) @(posedge clk_i);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
